// ===== src/pkcs1u_pkg.sv =====
// Shared types and constants for the PKCS #1 v1.5 unpad and check block.
// No dependencies; every other file in src imports this package.
package pkcs1u_pkg;

    localparam int MAX_BLOCK_BYTES_DEF = 512;
    localparam int ULEN_W              = 10;
    localparam int PAD_MIN_LEN         = 11;
    localparam int TDATA_W             = 24;
    localparam int TUSER_W             = 3;

    localparam logic MODE_SIGN = 1'b0;
    localparam logic MODE_ENC  = 1'b1;

    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] SIGN_PAD_INIT = 8'hFF;
    localparam logic [7:0] ENC_PAD_INIT  = 8'h00;
    localparam logic [7:0] HDR_TYPE_SIGN = 8'h01;
    localparam logic [7:0] HDR_TYPE_ENC  = 8'h02;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_PAD,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [ULEN_W-1:0] unpad_length;
        logic              pad_length_fail;
        logic              pad_bytes_fail;
        logic              block_end;
        logic              payload_valid;
        logic [7:0]        payload_byte;
    } result_t;

endpackage

// ===== src/pkcs1u_parser.sv =====
// Per-byte header, pad and separator parser with the block status logic.
// Depends on pkcs1u_pkg.
module pkcs1u_parser #(
    parameter int MAX_BLOCK_BYTES = pkcs1u_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                mode,
    output logic                has_result,
    output pkcs1u_pkg::result_t result
);
    import pkcs1u_pkg::*;

    localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BLOCK_BYTES);
    localparam logic [POS_W-1:0] MIN_LEN = POS_W'(PAD_MIN_LEN);
    localparam logic [POS_W-1:0] HDR_LEN = POS_W'(2);

    phase_t           phase_reg, phase_upd, phase_next;
    logic [POS_W-1:0] pos_reg, pos_upd;
    logic [7:0]       prev_reg, prev_upd;
    logic [POS_W-1:0] chg_reg, chg_upd;
    logic [POS_W-1:0] padlen_reg, padlen_upd;
    logic             hfail_reg, hfail_upd;
    logic             cur_mode_reg, cur_mode_upd;
    logic             oversize_reg, oversize_upd;

    logic             in_range;
    logic             pay_vld;
    logic [POS_W-1:0] dlen, idx;
    logic             short_blk, lfail, pfail;

    assign in_range = pos_reg < MAX_POS;

    // Phase sequencing.
    always_comb begin
        phase_upd = phase_reg;
        if (in_range) begin
            case (phase_reg)
                PH_HDR0: phase_upd = PH_HDR1;
                PH_HDR1: phase_upd = PH_PAD;
                PH_PAD:  phase_upd = (data_byte == BYTE_ZERO) ? PH_DATA : PH_PAD;
                PH_DATA: phase_upd = PH_DATA;
                default: phase_upd = PH_HDR0;
            endcase
        end
        phase_next = last_byte ? PH_HDR0 : phase_upd;
    end

    // Counters, pad tracking and the status computed on the last byte.
    always_comb begin
        pos_upd      = pos_reg;
        prev_upd     = prev_reg;
        chg_upd      = chg_reg;
        padlen_upd   = padlen_reg;
        hfail_upd    = hfail_reg;
        cur_mode_upd = cur_mode_reg;
        oversize_upd = oversize_reg;
        pay_vld      = 1'b0;
        if (in_range) begin
            pos_upd = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_HDR0: begin
                    cur_mode_upd = mode;
                    prev_upd     = (mode == MODE_ENC) ? ENC_PAD_INIT : SIGN_PAD_INIT;
                    hfail_upd    = hfail_reg | (data_byte != BYTE_ZERO);
                end
                PH_HDR1: begin
                    hfail_upd = hfail_reg | (data_byte !=
                        ((cur_mode_reg == MODE_ENC) ? HDR_TYPE_ENC : HDR_TYPE_SIGN));
                end
                PH_PAD: begin
                    if (data_byte == BYTE_ZERO) begin
                        padlen_upd = pos_reg + POS_W'(1);
                    end else begin
                        if (data_byte != prev_reg) begin
                            chg_upd = chg_reg + POS_W'(1);
                        end
                        prev_upd = data_byte;
                    end
                end
                PH_DATA: pay_vld = 1'b1;
                default: pay_vld = 1'b0;
            endcase
        end else begin
            oversize_upd = 1'b1;
        end

        // The separator counts as part of the pad; with no separator the
        // whole block is pad and the length check fails.
        dlen      = pos_upd;
        idx       = (phase_upd == PH_DATA) ? padlen_upd : dlen;
        short_blk = dlen < HDR_LEN;
        lfail     = short_blk || idx >= dlen || idx < MIN_LEN || oversize_upd;
        pfail     = short_blk || hfail_upd ||
                    ((cur_mode_upd == MODE_ENC) ? (chg_upd < (idx >> 2))
                                                : (chg_upd != '0));

        has_result             = pay_vld | last_byte;
        result.payload_byte    = pay_vld ? data_byte : BYTE_ZERO;
        result.payload_valid   = pay_vld;
        result.block_end       = last_byte;
        result.pad_bytes_fail  = last_byte & pfail;
        result.pad_length_fail = last_byte & lfail;
        result.unpad_length    = (last_byte && !short_blk) ? ULEN_W'(dlen - idx) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            pos_reg      <= '0;
            prev_reg     <= SIGN_PAD_INIT;
            chg_reg      <= '0;
            padlen_reg   <= '0;
            hfail_reg    <= 1'b0;
            cur_mode_reg <= MODE_SIGN;
            oversize_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            if (last_byte) begin
                pos_reg      <= '0;
                prev_reg     <= (mode == MODE_ENC) ? ENC_PAD_INIT : SIGN_PAD_INIT;
                chg_reg      <= '0;
                padlen_reg   <= '0;
                hfail_reg    <= 1'b0;
                cur_mode_reg <= MODE_SIGN;
                oversize_reg <= 1'b0;
            end else begin
                pos_reg      <= pos_upd;
                prev_reg     <= prev_upd;
                chg_reg      <= chg_upd;
                padlen_reg   <= padlen_upd;
                hfail_reg    <= hfail_upd;
                cur_mode_reg <= cur_mode_upd;
                oversize_reg <= oversize_upd;
            end
        end
    end

endmodule

// ===== src/pkcs1u_out_buf.sv =====
// Two-entry output register (main plus skid) for result beats, with port packing.
// Depends on pkcs1u_pkg.
module pkcs1u_out_buf (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  pkcs1u_pkg::result_t                  push_data,
    output logic                                 in_ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: payload_byte [7:0], unpad_length [17:8], zero fill [23:18].
    output logic [pkcs1u_pkg::TDATA_W-1:0]       m_tdata,
    // tuser: payload_valid [0], pad_bytes_fail [1], pad_length_fail [2].
    output logic [pkcs1u_pkg::TUSER_W-1:0]       m_tuser,
    output logic                                 m_tlast
);
    import pkcs1u_pkg::*;

    result_t main_reg, skid_reg;
    logic    main_vld_reg, skid_vld_reg;
    logic    pop;

    assign pop      = main_vld_reg & m_tready;
    assign in_ready = !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (pop) begin
            if (skid_vld_reg) begin
                skid_vld_reg <= 1'b0;
            end else begin
                main_vld_reg <= push;
            end
        end else if (!main_vld_reg) begin
            main_vld_reg <= push;
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_vld_reg) begin
            main_reg <= skid_reg;
        end else if (pop || !main_vld_reg) begin
            main_reg <= push_data;
        end
        if (push && main_vld_reg && !pop) begin
            skid_reg <= push_data;
        end
    end

    assign m_tvalid = main_vld_reg;
    assign m_tdata  = TDATA_W'({main_reg.unpad_length, main_reg.payload_byte});
    assign m_tuser  = {main_reg.pad_length_fail, main_reg.pad_bytes_fail,
                       main_reg.payload_valid};
    assign m_tlast  = main_reg.block_end;

endmodule

// ===== src/pkcs1_v15_unpad_check.sv =====
// PKCS #1 v1.5 unpad and check: takes one byte of a padded RSA block per beat and
// returns a result beat for every payload byte and for the block's last byte.
// A new input beat is accepted every cycle unless a result is held back by a full
// output buffer; a result passes through the input register and then the output
// register, and the two-entry output buffer keeps input flowing while a result waits. The
// padding type comes from cfg_data and is sampled when a block's first byte is
// processed. Status fields are valid on the beat with m_tlast set; payload
// bytes of a failed block have already been delivered and must be discarded.
// Depends on pkcs1u_pkg, pkcs1u_parser and pkcs1u_out_buf.
module pkcs1_v15_unpad_check #(
    parameter int MAX_BLOCK_BYTES = pkcs1u_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: data_byte [7:0].
    input  logic [7:0]                       s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: payload_byte [7:0], unpad_length [17:8], zero fill [23:18].
    output logic [pkcs1u_pkg::TDATA_W-1:0]   m_tdata,
    // tuser: payload_valid [0], pad_bytes_fail [1], pad_length_fail [2].
    output logic [pkcs1u_pkg::TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);
    import pkcs1u_pkg::*;

    logic       mode_reg;
    logic       in_vld_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       move;
    logic       has_result;
    logic       buf_ready;
    result_t    result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SIGN;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // A byte that yields no result advances even when the output is full.
    assign move     = in_vld_reg && (!has_result || buf_ready);
    assign s_tready = !in_vld_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pkcs1u_parser #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (move),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .mode      (mode_reg),
        .has_result(has_result),
        .result    (result)
    );

    pkcs1u_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (move && has_result),
        .push_data(result),
        .in_ready (buf_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A result that does not end a block must carry a payload byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0])
        else $error("result beat without payload or block end");

    // Status and length stay clear except on the block's last beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'b00 && m_tdata[17:8] == '0)
        else $error("status set on a beat that does not end a block");

    // A block that passes the length check has at least one data byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser[2] |-> m_tdata[17:8] != '0)
        else $error("length check passed with an empty payload");

    // A payload byte is zero whenever it is not marked valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
        else $error("payload byte not cleared on a status-only beat");

endmodule
